>>> sv/tssd_pkg.sv
// Package for the temperature seven-segment display block.
// Holds the shared types, constants and segment/fraction tables.
// No dependencies; imported by every module of the block.
package tssd_pkg;

   localparam int DIGITS       = 6;
   localparam int POS_W        = 3;
   localparam int SEG_W        = 8;
   localparam int RAW_W        = 12;
   localparam int DWELL_W      = 16;

   localparam logic [SEG_W-1:0]   SIGN_PATTERN = 8'h40;
   localparam logic [SEG_W-1:0]   POINT_BIT    = 8'h80;
   localparam logic [SEG_W-1:0]   SEG_BLANK    = 8'h00;
   localparam logic [DWELL_W-1:0] DWELL_RESET  = 16'd100;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef logic [DIGITS-1:0][SEG_W-1:0] disp_array_type;

   typedef struct packed {
      logic valid;
      logic kind;
   } stage_ctl_type;

   // Common-cathode pattern for one decimal digit.
   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
      logic [SEG_W-1:0] s;
      unique case (d)
         4'd0:    s = 8'h3f;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5b;
         4'd3:    s = 8'h4f;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6d;
         4'd6:    s = 8'h7d;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7f;
         4'd9:    s = 8'h6f;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // Hundredths of a degree for a sixteenths nibble, floor((25*f+2)/4),
   // as {tenths, hundredths}.
   function automatic logic [7:0] frac_digits(input logic [3:0] f);
      logic [7:0] r;
      unique case (f)
         4'd0:    r = 8'h00;
         4'd1:    r = 8'h06;
         4'd2:    r = 8'h13;
         4'd3:    r = 8'h19;
         4'd4:    r = 8'h25;
         4'd5:    r = 8'h31;
         4'd6:    r = 8'h38;
         4'd7:    r = 8'h44;
         4'd8:    r = 8'h50;
         4'd9:    r = 8'h56;
         4'd10:   r = 8'h63;
         4'd11:   r = 8'h69;
         4'd12:   r = 8'h75;
         4'd13:   r = 8'h81;
         4'd14:   r = 8'h88;
         default: r = 8'h94;
      endcase
      return r;
   endfunction

endpackage

>>> sv/tssd_decode.sv
// Sample decoder: turns a raw reading into the display byte array.
// Depends on tssd_pkg (tables, widths, display array type).
module tssd_decode (
   input  logic [tssd_pkg::RAW_W-1:0] raw_temp,
   output tssd_pkg::disp_array_type   disp_bytes
);
   import tssd_pkg::*;

   logic              neg;
   logic [RAW_W-1:0]  mag;
   logic [7:0]        whole;
   logic              hund;
   logic [6:0]        rem7;
   logic [14:0]       prod;
   logic [3:0]        tens;
   logic [3:0]        units;
   logic [7:0]        frac;

   // Integer degrees are mag/16 exactly; the sixteenths nibble gives
   // the hundredths through a small table.
   always_comb begin
      neg   = raw_temp[RAW_W-1];
      mag   = neg ? RAW_W'(13'h1000 - 13'(raw_temp)) : raw_temp;
      whole = mag[RAW_W-1:4];
      hund  = (whole >= 8'd100);
      rem7  = hund ? 7'(whole - 8'd100) : whole[6:0];
      prod  = 15'(rem7) * 15'd205;
      tens  = prod[14:11];
      units = 4'(rem7 - 7'(tens) * 7'd10);
      frac  = frac_digits(mag[3:0]);
   end

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         disp_bytes[i] = SEG_BLANK;
      end
      disp_bytes[0] = neg ? SIGN_PATTERN : SEG_BLANK;
      disp_bytes[1] = seg_of({3'b000, hund});
      disp_bytes[2] = seg_of(tens);
      disp_bytes[3] = seg_of(units) | POINT_BIT;
      disp_bytes[4] = seg_of(frac[7:4]);
      disp_bytes[5] = seg_of(frac[3:0]);
   end

endmodule

>>> sv/tssd_scan.sv
// Scan engine: display store, dwell/blank sequencing and result register.
// Depends on tssd_pkg (types, constants).
module tssd_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tssd_pkg::DWELL_W-1:0]    csr_wdata,
   input  tssd_pkg::stage_ctl_type         stage,
   input  tssd_pkg::disp_array_type        new_bytes,
   output logic                            stage_ready,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [tssd_pkg::POS_W-1:0]      out_select,
   output logic [tssd_pkg::SEG_W-1:0]      out_segments
);
   import tssd_pkg::*;

   logic [DWELL_W-1:0] dwell_ticks_ff;
   disp_array_type     disp_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [DWELL_W-1:0] dwell_count_ff, dwell_count_in;
   logic               blank_ff, blank_in;
   logic               out_valid_ff, out_valid_in;
   logic [POS_W-1:0]   sel_ff;
   logic [SEG_W-1:0]   seg_ff;

   logic               fire;
   logic               fire_tick;
   logic [DWELL_W-1:0] dwell_limit;
   logic [DWELL_W-1:0] count_inc;

   assign fire        = stage.valid && (stage.kind == KIND_SAMPLE || !out_valid_ff || out_ready);
   assign fire_tick   = fire && (stage.kind == KIND_TICK);
   assign stage_ready = !stage.valid || fire;
   assign dwell_limit = (dwell_ticks_ff == '0) ? DWELL_W'(1) : dwell_ticks_ff;
   assign count_inc   = dwell_count_ff + DWELL_W'(1);

   always_comb begin
      pos_in         = pos_ff;
      dwell_count_in = dwell_count_ff;
      blank_in       = blank_ff;
      if (fire_tick) begin
         if (blank_ff) begin
            blank_in = 1'b0;
            pos_in   = (pos_ff == POS_W'(DIGITS - 1)) ? '0 : pos_ff + POS_W'(1);
         end else if (count_inc >= dwell_limit) begin
            dwell_count_in = '0;
            blank_in       = 1'b1;
         end else begin
            dwell_count_in = count_inc;
         end
      end
   end

   assign out_valid_in = fire_tick ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= DWELL_RESET;
         disp_ff        <= '0;
         pos_ff         <= '0;
         dwell_count_ff <= '0;
         blank_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            dwell_ticks_ff <= csr_wdata;
         end
         if (fire && stage.kind == KIND_SAMPLE) begin
            disp_ff <= new_bytes;
         end
         pos_ff         <= pos_in;
         dwell_count_ff <= dwell_count_in;
         blank_ff       <= blank_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_tick) begin
         sel_ff <= pos_ff;
         seg_ff <= blank_ff ? SEG_BLANK : disp_ff[pos_ff];
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_select   = sel_ff;
   assign out_segments = seg_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(DIGITS - 1))
      else $error("scan position beyond last digit");

   a_blank_dark: assert property (@(posedge clock) disable iff (reset)
      fire_tick && blank_ff |=> out_segments == SEG_BLANK)
      else $error("blank tick produced lit segments");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fire_tick && !blank_ff |=> dwell_count_ff < $past(dwell_limit))
      else $error("dwell count reached its limit without blanking");

   a_sample_keeps_scan: assert property (@(posedge clock) disable iff (reset)
      fire && stage.kind == KIND_SAMPLE |=> $stable(pos_ff) && $stable(blank_ff))
      else $error("sample word disturbed the scan state");

endmodule

>>> sv/temperature_seven_segment_display.sv
// Temperature seven-segment display: top level, input register and ports.
// A tick word passes the input register, then the result register; a sample word
// updates the display store and yields no result. Throughput: one word per cycle unless
// rsp_tready holds off a tick word, set by the input register feeding the result register.
// Reset (synchronous, active high) blanks the display store, restarts the scan at
// position 0 and sets dwell_ticks to 100. Depends on tssd_pkg, tssd_decode, tssd_scan.
module temperature_seven_segment_display (
   input  logic        clock,
   input  logic        reset,
   // configuration: dwell_ticks
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] raw_temp, [15:12] zero
   input  logic        req_tuser,   // [0] kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] digit_select, [10:3] segments, [15:11] zero
);
   import tssd_pkg::*;

   // input register: one word waiting for the single processing pass
   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   logic [RAW_W-1:0]  in_raw_ff;

   logic              req_fire;
   logic              stage_ready;
   stage_ctl_type     stage;
   disp_array_type    new_bytes;
   logic [POS_W-1:0]  out_select;
   logic [SEG_W-1:0]  out_segments;

   // accept a new word when the register is empty or the held one leaves in this cycle
   assign req_tready  = stage_ready;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !stage_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset; load only on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_tuser;
         in_raw_ff  <= req_tdata[RAW_W-1:0];
      end
   end

   assign stage.valid = in_valid_ff;
   assign stage.kind  = in_kind_ff;

   // decode the held reading into display bytes (used only for sample words)
   tssd_decode u_decode (
      .raw_temp   (in_raw_ff),
      .disp_bytes (new_bytes)
   );

   // scan sequencing, display store and result register
   tssd_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .stage        (stage),
      .new_bytes    (new_bytes),
      .stage_ready  (stage_ready),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_select   (out_select),
      .out_segments (out_segments)
   );

   // pack the result word, digit_select in the lowest bits
   assign rsp_tdata = {5'b00000, out_segments, out_select};

endmodule

>>> tb/temperature_seven_segment_display_tb.sv
// Testbench for the temperature seven-segment display: drives sample and tick
// words, predicts every scan word in a scoreboard class and checks it in order.
// Depends on tssd_pkg and the temperature_seven_segment_display top level.
module temperature_seven_segment_display_tb;
   import tssd_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_WORDS  = 190;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [POS_W-1:0] sel;
      logic [SEG_W-1:0] seg;
   } scan_word_type;

   // Own model of the display store and the scan sequencer.
   class segment_scoreboard;
      logic [SEG_W-1:0]   digit_bytes[DIGITS];
      int                 scan_pos;
      bit [DWELL_W-1:0]   lit_count;
      bit                 blanking;
      bit [DWELL_W-1:0]   dwell_ticks;
      scan_word_type      expected_scan[$];
      int                 errors;
      logic [SEG_W-1:0]   digit_pattern[10];

      function new();
         digit_pattern = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                           8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
         foreach (digit_bytes[i]) digit_bytes[i] = SEG_BLANK;
         scan_pos    = 0;
         lit_count   = '0;
         blanking    = 1'b0;
         dwell_ticks = DWELL_RESET;
         errors      = 0;
      endfunction

      function void set_dwell(input logic [DWELL_W-1:0] v);
         dwell_ticks = v;
      endfunction

      // Update the store on a sample word, queue one scan word on a tick.
      function void note_word(input logic kind, input logic [RAW_W-1:0] raw);
         logic [12:0]      mag;
         int unsigned      v;
         int unsigned      lim;
         scan_word_type    w;
         if (kind != KIND_TICK) begin
            if (raw[RAW_W-1]) begin
               digit_bytes[0] = SIGN_PATTERN;
               mag = 13'h1000 - {1'b0, raw};
            end else begin
               digit_bytes[0] = SEG_BLANK;
               mag = {1'b0, raw};
            end
            v = (25 * int'(mag) + 2) / 4;
            digit_bytes[1] = digit_pattern[(v / 10000) % 10];
            digit_bytes[2] = digit_pattern[(v % 10000) / 1000];
            digit_bytes[3] = digit_pattern[(v % 1000) / 100] | POINT_BIT;
            digit_bytes[4] = digit_pattern[(v % 100) / 10];
            digit_bytes[5] = digit_pattern[v % 10];
         end else begin
            w.sel = scan_pos[POS_W-1:0];
            if (blanking) begin
               w.seg    = SEG_BLANK;
               blanking = 1'b0;
               scan_pos = (scan_pos + 1) % DIGITS;
            end else begin
               w.seg     = digit_bytes[scan_pos];
               lim       = (dwell_ticks == 0) ? 1 : dwell_ticks;
               lit_count = lit_count + 1'b1;
               if (lit_count >= lim) begin
                  lit_count = '0;
                  blanking  = 1'b1;
               end
            end
            expected_scan.push_back(w);
         end
      endfunction

      function void check_word(input logic [15:0] tdata);
         scan_word_type exp_w;
         if (expected_scan.size() == 0) begin
            $display("%0t: scan word expected none actual %h", $time, tdata);
            errors++;
         end else begin
            exp_w = expected_scan.pop_front();
            if (tdata[2:0] !== exp_w.sel) begin
               $display("%0t: digit_select expected %0d actual %0d",
                        $time, exp_w.sel, tdata[2:0]);
               errors++;
            end
            if (tdata[10:3] !== exp_w.seg) begin
               $display("%0t: segments expected %h actual %h",
                        $time, exp_w.seg, tdata[10:3]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_scan.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] raw_temp, [15:12] zero
   logic        req_tuser;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [2:0] digit_select, [10:3] segments, [15:11] zero

   segment_scoreboard sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_request;
   int  cycle_count;

   temperature_seven_segment_display u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog: give up well past the slowest legal run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL temperature_seven_segment_display");
         $finish;
      end
   end

   // Receiver: stall at random, or hold off for a long stretch on request so the
   // block backs up and drops req_tready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every result word taken at a rising edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      end
   end

   // Offer one word after an optional random gap; leave tvalid high on return,
   // the next call or a drain moves it at the very next falling edge.
   task automatic send_word(input logic kind, input logic [RAW_W-1:0] raw);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'h0, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(kind, raw);
   endtask

   // Drop tvalid and wait until every predicted scan word has come back; then
   // let a sample word still in the pipe settle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dwell(input logic [DWELL_W-1:0] v);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_dwell(v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_word();
      int pick;
      logic [RAW_W-1:0] raw;
      raw = RAW_W'($urandom_range(0, 4095));
      if ($urandom_range(99) < 75) begin
         send_word(KIND_TICK, raw);
      end else begin
         pick = $urandom_range(0, 9);
         unique case (pick)
            0:       raw = 12'h800;
            1:       raw = 12'h7ff;
            2:       raw = 12'hfff;
            3:       raw = 12'h000;
            default: ;
         endcase
         send_word(KIND_SAMPLE, raw);
      end
   endtask

   initial begin
      logic [DWELL_W-1:0] dwell_plan[6];
      sb            = new();
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = KIND_SAMPLE;
      hold_request  = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 55;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: blank store under the reset dwell, then the reading extremes
      // with one-tick dwell so the scan walks every position.
      repeat (3) send_word(KIND_TICK, 12'h000);
      write_dwell(16'd1);
      send_word(KIND_SAMPLE, 12'h800);     // most negative reading, -128.00
      repeat (4) send_word(KIND_TICK, 12'h000);
      send_word(KIND_SAMPLE, 12'h7ff);     // largest positive reading
      repeat (4) send_word(KIND_TICK, 12'h000);
      send_word(KIND_SAMPLE, 12'hfff);     // smallest negative magnitude
      repeat (2) send_word(KIND_TICK, 12'h000);
      send_word(KIND_SAMPLE, 12'h001);
      repeat (2) send_word(KIND_TICK, 12'h000);
      send_word(KIND_SAMPLE, 12'h00f);     // all fraction bits set
      repeat (2) send_word(KIND_TICK, 12'h000);

      // Random phases: zero dwell acts as one, then mid, full-scale and small.
      dwell_plan = '{16'd0, 16'd2, 16'hffff, 16'd1, 16'd5, 16'd3};
      dwell_plan[5] = DWELL_W'($urandom_range(1, 12));
      for (int ph = 0; ph < 6; ph++) begin
         write_dwell(dwell_plan[ph]);
         if (ph < 2) begin
            send_idle_pct = 16;
            recv_idle_pct = 55;
         end else if (ph < 4) begin
            send_idle_pct = 55;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Back up the block once; pause the sender until drained once.
            if (ph == 4 && n == 40) hold_request = 1'b1;
            if (ph == 2 && n == 100) drain();
            send_random_word();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS temperature_seven_segment_display");
      end else begin
         $display("FAIL temperature_seven_segment_display");
      end
      $finish;
   end

endmodule
